/* rtl/pspa_pkg.sv */
// Package with the types, codes and constants of the paged slot pool allocator.
package pspa_pkg;

  localparam int POOL_CAP  = 256;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int GRP_W     = 16;
  localparam int N_GRP     = POOL_CAP / GRP_W;
  localparam int GRP_IDX_W = $clog2(N_GRP);
  localparam int GRP_LO_W  = $clog2(GRP_W);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_LOCK    = 3'd2,
    CMD_UNLOCK  = 3'd3,
    CMD_USE     = 3'd4,
    CMD_RELEASE = 3'd5,
    CMD_DELETE  = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_USE     = 3'd1;
  localparam logic [2:0] ST_LOCK    = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_DELETE  = 3'd4;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [2:0]        status_out;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  total_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TEST,
    S_RECLAIM,
    S_RECOUNT,
    S_ADD,
    S_ENC,
    S_TAKE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic reclaim;
    logic recount;
    logic add_page;
    logic fail;
    logic enc;
    logic take;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic alloc_req;
    logic free_any;
    logic cand_any;
    logic can_add;
    logic recount_last;
  } dstat_t;

endpackage

/* rtl/pspa_ctrl.sv */
// Controller state machine that sequences commands, reclaim, page growth and slot search.
module pspa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pspa_pkg::dstat_t st,
  output pspa_pkg::ctrl_t  ctl
);
  import pspa_pkg::*;

  state_t state, state_next;
  logic   reclaimed, reclaimed_next;
  logic   after_add, after_add_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      reclaimed <= 1'b0;
      after_add <= 1'b0;
    end else begin
      state     <= state_next;
      reclaimed <= reclaimed_next;
      after_add <= after_add_next;
    end
  end

  always_comb begin
    state_next     = state;
    reclaimed_next = reclaimed;
    after_add_next = after_add;
    ctl            = '0;
    busy           = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load       = 1'b1;
          reclaimed_next = 1'b0;
          state_next     = st.alloc_req ? S_TEST : S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_FINISH;
      end
      S_TEST: begin
        if (st.free_any && st.cand_any) begin
          state_next = S_ENC;
        end else if (!reclaimed) begin
          reclaimed_next = 1'b1;
          after_add_next = st.free_any;
          state_next     = S_RECLAIM;
        end else begin
          state_next = S_ADD;
        end
      end
      S_RECLAIM: begin
        ctl.reclaim = 1'b1;
        state_next  = S_RECOUNT;
      end
      S_RECOUNT: begin
        ctl.recount = 1'b1;
        if (st.recount_last) begin
          state_next = after_add ? S_ADD : S_TEST;
        end
      end
      S_ADD: begin
        if (st.can_add) begin
          ctl.add_page = 1'b1;
          state_next   = S_TEST;
        end else begin
          ctl.fail   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_ENC: begin
        ctl.enc    = 1'b1;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        ctl.take   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/pspa_dpath.sv */
// Datapath with the slot bitmaps, status memory, pool counters, slot search and result register.
module pspa_dpath #(
  parameter int SLOTS_PER_PAGE = 64,
  parameter int MAX_PAGES      = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  pspa_pkg::req_t   req,
  input  pspa_pkg::ctrl_t  ctl,
  output pspa_pkg::dstat_t st,
  output logic             done,
  output pspa_pkg::rsp_t   rsp
);
  import pspa_pkg::*;

  localparam int PAGE_W = $clog2(MAX_PAGES + 1);
  localparam logic [CNT_W-1:0] STEP =
    (SLOTS_PER_PAGE >= POOL_CAP) ? CNT_W'(POOL_CAP) : CNT_W'(SLOTS_PER_PAGE);

  function automatic logic [GRP_LO_W:0] pop_grp(input logic [GRP_W-1:0] v);
    logic [GRP_LO_W:0] c;
    c = '0;
    for (int i = 0; i < GRP_W; i++) begin
      c = c + (GRP_LO_W+1)'(v[i]);
    end
    return c;
  endfunction

  logic [POOL_CAP-1:0] in_use, is_none, is_del, st_wv, act, cand;
  logic [2:0]          st_mem [POOL_CAP];
  logic [2:0]          rd_data;
  logic                rd_vld;
  logic [PAGE_W-1:0]   page_cnt;
  logic [CNT_W-1:0]    total_cnt, used_cnt;
  logic [CNT_W:0]      total_sum;
  logic [GRP_IDX_W-1:0] grp, g_pick, g_q;
  logic [GRP_LO_W-1:0] lo_pick;
  logic [GRP_W-1:0]    word_q;
  cmd_t                cmd_q;
  logic [SLOT_W-1:0]   slot_q, idx;
  logic                in_rng, mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [2:0]          mem_wd, exec_val;
  logic                res_ok, res_query;
  logic [SLOT_W-1:0]   res_slot;
  logic [2:0]          res_stat;

  always_comb begin
    for (int i = 0; i < POOL_CAP; i++) begin
      act[i] = (CNT_W'(i) < total_cnt);
    end
    cand = act & ~in_use & ~is_del;
  end

  always_comb begin
    g_pick = '0;
    for (int g = N_GRP - 1; g >= 0; g--) begin
      if (|cand[g*GRP_W +: GRP_W]) g_pick = GRP_IDX_W'(g);
    end
    lo_pick = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (word_q[b]) lo_pick = GRP_LO_W'(b);
    end
    idx = {g_q, lo_pick};
  end

  assign in_rng    = ({1'b0, slot_q} < total_cnt);
  assign total_sum = {1'b0, total_cnt} + {1'b0, STEP};

  always_comb begin
    unique case (cmd_q)
      CMD_FREE:    exec_val = ST_NONE;
      CMD_LOCK:    exec_val = ST_LOCK;
      CMD_UNLOCK:  exec_val = ST_USE;
      CMD_USE:     exec_val = ST_USE;
      CMD_RELEASE: exec_val = ST_RELEASE;
      CMD_DELETE:  exec_val = ST_DELETE;
      default:     exec_val = ST_NONE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_q;
    mem_wd = exec_val;
    if (ctl.take) begin
      mem_we = 1'b1;
      mem_wa = idx;
      mem_wd = ST_USE;
    end else if (ctl.exec && in_rng && (cmd_q != CMD_QUERY)) begin
      mem_we = 1'b1;
    end
  end

  assign st.alloc_req    = (req.cmd == CMD_ALLOC);
  assign st.free_any     = |(act & ~in_use);
  assign st.cand_any     = |cand;
  assign st.can_add      = (page_cnt < PAGE_W'(MAX_PAGES)) && (total_cnt < CNT_W'(POOL_CAP));
  assign st.recount_last = (grp == GRP_IDX_W'(N_GRP - 1));

  always_ff @(posedge clk) begin
    if (mem_we) st_mem[mem_wa] <= mem_wd;
    rd_data <= st_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      is_none   <= '1;
      is_del    <= '0;
      st_wv     <= '0;
      page_cnt  <= PAGE_W'(1);
      total_cnt <= STEP;
      used_cnt  <= '0;
      grp       <= '0;
      done      <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (mem_we) begin
        st_wv[mem_wa]   <= 1'b1;
        is_none[mem_wa] <= (mem_wd == ST_NONE);
        is_del[mem_wa]  <= (mem_wd == ST_DELETE);
      end
      if (ctl.exec && in_rng && (cmd_q == CMD_FREE) && in_use[slot_q]) begin
        in_use[slot_q] <= 1'b0;
        used_cnt       <= used_cnt - CNT_W'(1);
      end
      if (ctl.take) begin
        in_use[idx] <= 1'b1;
        used_cnt    <= used_cnt + CNT_W'(1);
      end
      if (ctl.reclaim) begin
        in_use   <= in_use & ~is_none;
        used_cnt <= '0;
        grp      <= '0;
      end
      if (ctl.recount) begin
        used_cnt <= used_cnt + CNT_W'(pop_grp(in_use[grp*GRP_W +: GRP_W]));
        grp      <= grp + GRP_IDX_W'(1);
      end
      if (ctl.add_page) begin
        page_cnt  <= page_cnt + PAGE_W'(1);
        total_cnt <= (total_sum > (CNT_W+1)'(POOL_CAP)) ? CNT_W'(POOL_CAP)
                                                       : total_sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= st_wv[slot_q];
    if (ctl.load) begin
      cmd_q  <= req.cmd;
      slot_q <= req.slot;
    end
    if (ctl.enc) begin
      g_q    <= g_pick;
      word_q <= cand[g_pick*GRP_W +: GRP_W];
    end
    if (ctl.exec) begin
      res_slot  <= slot_q;
      res_query <= in_rng && (cmd_q == CMD_QUERY);
      res_ok    <= in_rng && ((cmd_q != CMD_FREE) || in_use[slot_q]);
      res_stat  <= in_rng ? exec_val : ST_NONE;
    end
    if (ctl.fail) begin
      res_ok    <= 1'b0;
      res_slot  <= '0;
      res_stat  <= ST_NONE;
      res_query <= 1'b0;
    end
    if (ctl.take) begin
      res_ok    <= 1'b1;
      res_slot  <= idx;
      res_stat  <= ST_USE;
      res_query <= 1'b0;
    end
    if (ctl.finish) begin
      rsp.ok          <= res_ok;
      rsp.slot_out    <= res_slot;
      rsp.status_out  <= res_query ? (rd_vld ? rd_data : ST_NONE) : res_stat;
      rsp.free_count  <= total_cnt - used_cnt;
      rsp.used_count  <= used_cnt;
      rsp.total_count <= total_cnt;
    end
  end

endmodule

/* rtl/paged_slot_pool_allocator_top.sv */
// Top level of the paged slot pool allocator: controller and datapath.
// Free, status and query commands: the execute and finish states run, then done rises.
// Allocate: test, encode, take and finish with a usable slot; else a reclaim pass (release, recount of
// the in-use bitmap group by group, retest) comes first, a page is added when needed, or it fails.
// One command at a time; the next is taken in the cycle its predecessor's result beat shows.
// Synchronous reset: all slots free with status none, one page active; results cannot stall.
module paged_slot_pool_allocator_top #(
  parameter int SLOTS_PER_PAGE = 64,
  parameter int MAX_PAGES      = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pspa_pkg::req_t req,
  output logic           done,
  output pspa_pkg::rsp_t rsp
);
  import pspa_pkg::*;

  ctrl_t  ctl;
  dstat_t st;

  pspa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  pspa_dpath #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .MAX_PAGES      (MAX_PAGES)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .st   (st),
    .done (done),
    .rsp  (rsp)
  );

endmodule

/* rtl/pspa_chk.sv */
// Port-level checker for the paged slot pool allocator and its bind to the top level.
module pspa_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input pspa_pkg::rsp_t rsp
);
  import pspa_pkg::*;

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (({1'b0, rsp.free_count} + {1'b0, rsp.used_count}) == {1'b0, rsp.total_count}))
    else $error("free and used counts do not add up to the active slot count");

  a_fail_status: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.ok) |-> (rsp.status_out == ST_NONE))
    else $error("failed command reports a status other than none");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while the block is still busy");

endmodule

bind paged_slot_pool_allocator_top pspa_chk u_chk (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the paged slot pool allocator with its own pool model.
`timescale 1ns / 1ps

module tb_top;
  import pspa_pkg::*;

  localparam int SPP       = 64;
  localparam int MAXP      = 4;
  localparam int N_ITEMS   = 600;
  localparam int MAX_CYC   = 1000000;
  localparam int TAIL_CYC  = 40;

  typedef struct {
    req_t req;
    int   gap;
    bit   drain;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  cmd_beat_t   cmd_queue[$];
  rsp_t        rsp_expected[$];
  int          n_acc = 0;
  int          n_done = 0;
  int          idle_cnt = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          gap_max = 0;

  int unsigned pool_pages;
  bit          slot_taken[POOL_CAP];
  logic [2:0]  slot_mark[POOL_CAP];

  paged_slot_pool_allocator_top #(
    .SLOTS_PER_PAGE(SPP),
    .MAX_PAGES(MAXP)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #2 clk = ~clk;

  function automatic int unsigned active_slots();
    longint unsigned t;
    t = longint'(pool_pages) * SPP;
    return (t > POOL_CAP) ? POOL_CAP : int'(t);
  endfunction

  function automatic int unsigned free_slots();
    int unsigned c;
    c = 0;
    for (int i = 0; i < active_slots(); i++)
      if (!slot_taken[i]) c++;
    return c;
  endfunction

  function automatic void reclaim_slots();
    for (int i = 0; i < POOL_CAP; i++)
      if (slot_taken[i] && slot_mark[i] == ST_NONE) slot_taken[i] = 1'b0;
  endfunction

  function automatic bit grow_pool();
    int unsigned lo;
    int unsigned hi;
    lo = active_slots();
    if (pool_pages >= MAXP || lo >= POOL_CAP) return 1'b0;
    pool_pages++;
    hi = active_slots();
    for (int unsigned i = lo; i < hi; i++) begin
      slot_taken[i] = 1'b0;
      slot_mark[i] = ST_NONE;
    end
    return 1'b1;
  endfunction

  function automatic int grab_lowest_slot();
    int unsigned n;
    for (int unsigned tries = 0; tries <= MAXP + 1; tries++) begin
      if (free_slots() == 0) reclaim_slots();
      if (free_slots() == 0) begin
        if (grow_pool()) continue;
        return -1;
      end
      n = active_slots();
      for (int i = 0; i < n; i++) begin
        if (!slot_taken[i] && slot_mark[i] != ST_DELETE) begin
          slot_taken[i] = 1'b1;
          slot_mark[i] = ST_USE;
          return i;
        end
      end
      reclaim_slots();
      if (!grow_pool()) return -1;
    end
    return -1;
  endfunction

  function automatic rsp_t pool_step(input req_t r);
    rsp_t        o;
    int          a;
    int unsigned s;
    int unsigned used;
    o = '0;
    s = 32'(r.slot);
    o.slot_out = r.slot;
    used = 0;
    if (r.cmd == CMD_ALLOC) begin
      a = grab_lowest_slot();
      if (a >= 0) begin
        o.ok = 1'b1;
        o.slot_out = a[SLOT_W-1:0];
        o.status_out = slot_mark[a];
      end else begin
        o.slot_out = '0;
      end
    end else if (s < active_slots()) begin
      case (r.cmd)
        CMD_FREE: begin
          slot_mark[s] = ST_NONE;
          if (slot_taken[s]) begin
            slot_taken[s] = 1'b0;
            o.ok = 1'b1;
          end
        end
        CMD_LOCK: begin
          slot_mark[s] = ST_LOCK;
          o.ok = 1'b1;
        end
        CMD_UNLOCK, CMD_USE: begin
          slot_mark[s] = ST_USE;
          o.ok = 1'b1;
        end
        CMD_RELEASE: begin
          slot_mark[s] = ST_RELEASE;
          o.ok = 1'b1;
        end
        CMD_DELETE: begin
          slot_mark[s] = ST_DELETE;
          o.ok = 1'b1;
        end
        default: begin
          o.ok = 1'b1;
        end
      endcase
      o.status_out = slot_mark[s];
    end
    for (int i = 0; i < POOL_CAP; i++)
      if (slot_taken[i]) used++;
    o.free_count = CNT_W'(free_slots());
    o.used_count = CNT_W'(used);
    o.total_count = CNT_W'(active_slots());
    return o;
  endfunction

  task automatic push_cmd(input cmd_t c, input int s, input bit hold);
    cmd_beat_t b;
    b.req.cmd = c;
    b.req.slot = s[SLOT_W-1:0];
    b.gap = $urandom_range(0, gap_max);
    b.drain = hold;
    cmd_queue = {cmd_queue, b};
  endtask

  function automatic int pick_slot();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 63);
    if (r < 65) return $urandom_range(0, 127);
    return $urandom_range(0, 255);
  endfunction

  // Driver: start stays high across back-to-back beats and gets one assignment per edge.
  always @(posedge clk) begin
    if (!rst && (!start || !busy)) begin
      if (start) begin
        rsp_expected = {rsp_expected, pool_step(req)};
        n_acc <= n_acc + 1;
      end
      if (cmd_queue.size() > 0 &&
          (start ? (cmd_queue[0].gap == 0 && !cmd_queue[0].drain)
                 : (idle_cnt >= cmd_queue[0].gap &&
                    (!cmd_queue[0].drain || n_done == n_acc)))) begin
        req <= cmd_queue[0].req;
        start <= 1'b1;
        idle_cnt <= 0;
        void'(cmd_queue.pop_front());
      end else begin
        start <= 1'b0;
        idle_cnt <= start ? 0 : idle_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (n_done >= n_acc) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result beat: slot_out=%0d ok=%0b", rsp.slot_out, rsp.ok);
      end else begin
        if (rsp !== rsp_expected[n_done]) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch on result %0d", n_done);
            $display("  expected ok=%0b slot=%0d status=%0d free=%0d used=%0d total=%0d",
                     rsp_expected[n_done].ok, rsp_expected[n_done].slot_out,
                     rsp_expected[n_done].status_out, rsp_expected[n_done].free_count,
                     rsp_expected[n_done].used_count, rsp_expected[n_done].total_count);
            $display("  actual   ok=%0b slot=%0d status=%0d free=%0d used=%0d total=%0d",
                     rsp.ok, rsp.slot_out, rsp.status_out, rsp.free_count,
                     rsp.used_count, rsp.total_count);
          end
        end
        n_done <= n_done + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYC) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int base;
    int len;
    int kind;
    pool_pages = 1;
    for (int i = 0; i < POOL_CAP; i++) begin
      slot_taken[i] = 1'b0;
      slot_mark[i] = ST_NONE;
    end

    gap_max = 0;
    push_cmd(CMD_QUERY, 0, 1'b0);
    push_cmd(CMD_QUERY, 63, 1'b0);
    push_cmd(CMD_QUERY, 64, 1'b0);
    push_cmd(CMD_QUERY, 255, 1'b0);
    push_cmd(CMD_FREE, 5, 1'b0);
    push_cmd(CMD_LOCK, 3, 1'b0);
    push_cmd(CMD_ALLOC, 0, 1'b0);
    push_cmd(CMD_ALLOC, 170, 1'b0);
    push_cmd(CMD_ALLOC, 255, 1'b0);
    gap_max = 5;
    push_cmd(CMD_LOCK, 1, 1'b0);
    push_cmd(CMD_UNLOCK, 1, 1'b0);
    push_cmd(CMD_USE, 2, 1'b0);
    push_cmd(CMD_RELEASE, 2, 1'b0);
    push_cmd(CMD_DELETE, 0, 1'b0);
    push_cmd(CMD_FREE, 0, 1'b1);
    push_cmd(CMD_DELETE, 0, 1'b0);
    push_cmd(CMD_ALLOC, 85, 1'b0);
    push_cmd(CMD_RELEASE, 200, 1'b0);
    push_cmd(CMD_FREE, 1, 1'b0);
    push_cmd(CMD_FREE, 1, 1'b0);
    push_cmd(CMD_DELETE, 128, 1'b0);
    push_cmd(CMD_QUERY, 0, 1'b0);
    push_cmd(CMD_ALLOC, 0, 1'b0);

    while (cmd_queue.size() < N_ITEMS + 23) begin
      kind = $urandom_range(0, 5);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      case (kind)
        0: begin
          len = $urandom_range(30, 80);
          repeat (len) begin
            if ($urandom_range(0, 9) < 9) push_cmd(CMD_ALLOC, $urandom_range(0, 255), 1'b0);
            else push_cmd(cmd_t'($urandom_range(1, 7)), pick_slot(), 1'b0);
          end
        end
        1: begin
          len = $urandom_range(20, 50);
          repeat (len) push_cmd(cmd_t'($urandom_range(0, 7)), pick_slot(), 1'b0);
        end
        2: begin
          base = pick_slot();
          len = $urandom_range(5, 30);
          for (int i = 0; i < len; i++) push_cmd(CMD_FREE, (base + i) % POOL_CAP, 1'b0);
        end
        3: begin
          base = pick_slot();
          len = $urandom_range(4, 24);
          for (int i = 0; i < len; i++) push_cmd(CMD_DELETE, (base + i) % POOL_CAP, 1'b0);
          repeat ($urandom_range(3, 8)) push_cmd(CMD_ALLOC, $urandom_range(0, 255), 1'b0);
        end
        4: begin
          len = $urandom_range(10, 30);
          repeat (len) push_cmd(cmd_t'($urandom_range(1, 7)), $urandom_range(0, 255), 1'b0);
        end
        default: begin
          push_cmd(cmd_t'($urandom_range(0, 7)), pick_slot(), 1'b1);
          repeat ($urandom_range(2, 10)) push_cmd(cmd_t'($urandom_range(0, 7)), pick_slot(), 1'b0);
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (cmd_queue.size() != 0 || start || n_done != n_acc) @(negedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_cnt == 0 && n_done == n_acc) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pspa_pkg.sv
rtl/pspa_ctrl.sv
rtl/pspa_dpath.sv
rtl/paged_slot_pool_allocator_top.sv
rtl/pspa_chk.sv
tb/tb_top.sv
